/* hdl/harmonic_voice_envelope_synth_assert.svh */
// Assertion macros for the voice synthesiser.
// Both expect clk and rst_n in scope.
`ifndef HARMONIC_VOICE_ENVELOPE_SYNTH_ASSERT_SVH
`define HARMONIC_VOICE_ENVELOPE_SYNTH_ASSERT_SVH

// Same-cycle implication.
`define HVES_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HVES_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/hves_pkg.sv */
`timescale 1ns / 1ps
package hves_pkg;

  localparam int MUL_A_W = 35;
  localparam int MUL_B_W = 17;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Reciprocal scale: q = (x * m) >> RECIP_SHIFT is exact for x < 2**XCLAMP_W
  localparam int RECIP_SHIFT = 29;
  localparam int XCLAMP_W    = 22;
  localparam logic [29:0] RECIP_1   = 30'd536870912;
  localparam logic [29:0] RECIP_3   = 30'd178956971;
  localparam logic [29:0] RECIP_25  = 30'd21474837;
  localparam logic [29:0] RECIP_125 = 30'd4294968;

  localparam logic [2:0] VOICE_FLUTE   = 3'd1;
  localparam logic [2:0] VOICE_TRUMPET = 3'd2;
  localparam logic [2:0] VOICE_CLARI   = 3'd3;
  localparam logic [2:0] VOICE_PIANO   = 3'd4;
  localparam logic [2:0] VOICE_HOLO    = 3'd5;

  localparam logic REG_VOICE = 1'b0;
  localparam logic REG_PEAK  = 1'b1;

  typedef enum logic [1:0] {
    WK_SINE,
    WK_SAW,
    WK_SQUARE,
    WK_TRI
  } wave_kind_t;

  typedef struct packed {
    wave_kind_t  kind;
    logic [13:0] attack;
    logic [3:0]  att_k;    // attack = 2**att_k * odd divisor
    logic [29:0] att_m;
    logic [3:0]  rel_div;
    logic [3:0]  rel_k;
    logic [29:0] rel_m;
    logic [15:0] w1;
    logic [2:0]  h1;
    logic [15:0] w2;
    logic [2:0]  h2;
  } voice_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_W0,
    ST_W1,
    ST_W2,
    ST_W3,
    ST_W4,
    ST_GAIN,
    ST_P0,
    ST_P1,
    ST_P2,
    ST_D0,
    ST_D1,
    ST_D2
  } state_t;

  typedef struct packed {
    logic ready;
    logic finish;
  } ctrl_t;

  function automatic voice_t voice_params(input logic [2:0] sel);
    voice_t v;
    case (sel)
      VOICE_FLUTE:   v = '{WK_SINE,   14'd6400,  4'd8, RECIP_25,  4'd2, 4'd1, RECIP_1,
                           16'd21845, 3'd2, 16'd10923, 3'd4};
      VOICE_TRUMPET: v = '{WK_SAW,    14'd16000, 4'd7, RECIP_125, 4'd8, 4'd3, RECIP_1,
                           16'd21845, 3'd3, 16'd10923, 3'd5};
      VOICE_CLARI:   v = '{WK_SQUARE, 14'd6400,  4'd8, RECIP_25,  4'd6, 4'd1, RECIP_3,
                           16'd32768, 3'd2, 16'd21845, 3'd4};
      VOICE_HOLO:    v = '{WK_TRI,    14'd6400,  4'd8, RECIP_25,  4'd2, 4'd1, RECIP_1,
                           16'd24576, 3'd2, 16'd16384, 3'd3};
      default:       v = '{WK_SINE,   14'd64,    4'd6, RECIP_1,   4'd2, 4'd1, RECIP_1,
                           16'd21845, 3'd2, 16'd10923, 3'd5};
    endcase
    return v;
  endfunction

endpackage

/* hdl/harmonic_voice_envelope_synth.sv */
`timescale 1ns / 1ps
// A new request is taken only while the sequencer is idle, so each sample
//   is finished before the next is accepted. One registered multiplier is shared
//   by both harmonic weights, the attack gain, the two-part envelope product
//   and the two-part reciprocal divide, all in sequence.
// Reset (rst_n low, synchronous): phase and sample index to zero, voice to
//   piano, peak volume to 16384, sequencer idle, output empty.
`include "harmonic_voice_envelope_synth_assert.svh"
module harmonic_voice_envelope_synth import hves_pkg::*; #(
  parameter int PHASE_BITS      = 24,
  parameter int SINE_TABLE_BITS = 8,
  parameter int INDEX_BITS      = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [23:0] phase_step
  input  logic [0:0]  in_tuser,   // [0] note_start
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] sample_out
  output logic [1:0]  out_tuser,  // [0] was_clipped, [1] envelope_ended
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int ROM_N = 2 ** SINE_TABLE_BITS;
  localparam int SUM_W = (PHASE_BITS > 24) ? PHASE_BITS : 24;

  typedef logic signed [16:0] rom_t [ROM_N];

  // Quarter-wave polynomial, evaluated at elaboration only.
  function automatic logic signed [16:0] rom_entry(input int k);
    int          qbits;
    logic [1:0]  q;
    logic [63:0] u, u2, t;
    qbits = SINE_TABLE_BITS - 2;
    q  = 2'((k >> qbits) & 3);
    u  = 64'(k & ((1 << qbits) - 1)) << (15 - qbits);
    if (q[0]) u = 64'd32768 - u;
    u2 = (u * u) >> 15;
    t  = (64'd2611 * u2) >> 15;
    t  = 64'd21167 - t;
    t  = (t * u2) >> 15;
    t  = 64'd51472 - t;
    t  = (t * u) >> 15;
    if (t > 64'd32767) t = 64'd32767;
    return q[1] ? -$signed(17'(t)) : $signed(17'(t));
  endfunction

  function automatic rom_t build_rom();
    rom_t r;
    for (int k = 0; k < ROM_N; k++) r[k] = rom_entry(k);
    return r;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [2:0]  voice_r;
  logic [14:0] peak_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    case (cfg_paddr[2])
      REG_VOICE: cfg_prdata = {29'd0, voice_r};
      REG_PEAK:  cfg_prdata = {17'd0, peak_r};
      default:   cfg_prdata = '0;
    endcase
  end

  voice_t vc;
  assign vc = voice_params(voice_r);

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  state_t state_r, state_nxt;
  ctrl_t  ctrl;
  logic   out_valid_r;
  logic   in_req, out_req;

  assign in_req  = in_tvalid && in_tready;
  assign out_req = out_tvalid && out_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_req) state_nxt = ST_W0;
      ST_W0:   state_nxt = ST_W1;
      ST_W1:   state_nxt = ST_W2;
      ST_W2:   state_nxt = ST_W3;
      ST_W3:   state_nxt = ST_W4;
      ST_W4:   state_nxt = ST_GAIN;
      ST_GAIN: state_nxt = ST_P0;
      ST_P0:   state_nxt = ST_P1;
      ST_P1:   state_nxt = ST_P2;
      ST_P2:   state_nxt = ST_D0;
      ST_D0:   state_nxt = ST_D1;
      ST_D1:   state_nxt = ST_D2;
      ST_D2:   if (ctrl.finish) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl.ready  = 1'b0;
    ctrl.finish = 1'b0;
    case (state_r)
      ST_IDLE: ctrl.ready  = 1'b1;
      // hold the last step until the output register is free
      ST_D2:   ctrl.finish = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  assign in_tready = ctrl.ready;

  // ---------------------------------------------------------------------
  // Note state: phase and sample index advance once per request
  // ---------------------------------------------------------------------
  logic [PHASE_BITS-1:0] phase_r, ph_cur;
  logic [INDEX_BITS-1:0] index_r, idx_cur;

  assign ph_cur  = in_tuser[0] ? '0 : phase_r;
  assign idx_cur = in_tuser[0] ? '0 : index_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= '0;
      index_r     <= '0;
      voice_r     <= VOICE_PIANO;
      peak_r      <= 15'd16384;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        case (cfg_paddr[2])
          REG_VOICE: voice_r <= cfg_pwdata[2:0];
          REG_PEAK:  peak_r  <= cfg_pwdata[14:0];
          default: ;
        endcase
      end
      if (in_req) begin
        phase_r <= PHASE_BITS'(SUM_W'(ph_cur) + SUM_W'(in_tdata));
        index_r <= (&idx_cur) ? idx_cur : idx_cur + 1'b1;
      end
      if (ctrl.finish)  out_valid_r <= 1'b1;
      else if (out_req) out_valid_r <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------
  // Waveform unit: one lookup per cycle, harmonic chosen by step
  // ---------------------------------------------------------------------
  logic [PHASE_BITS-1:0] ph_w_r;
  logic [INDEX_BITS-1:0] idx_w_r;
  logic                  rest_r;
  logic [31:0]           p32, ph_h;
  logic [2:0]            h_sel;
  logic signed [16:0]    wave_v;
  logic [16:0]           tri_u;

  assign p32 = 32'(ph_w_r) << (32 - PHASE_BITS);

  always_comb begin
    case (state_r)
      ST_W1:   h_sel = vc.h1;
      ST_W2:   h_sel = vc.h2;
      default: h_sel = 3'd1;
    endcase
    case (h_sel)
      3'd2:    ph_h = p32 << 1;
      3'd3:    ph_h = p32 + (p32 << 1);
      3'd4:    ph_h = p32 << 2;
      3'd5:    ph_h = p32 + (p32 << 2);
      default: ph_h = p32;
    endcase
  end

  assign tri_u = ph_h[31:15];

  always_comb begin
    case (vc.kind)
      WK_SINE:   wave_v = SINE_ROM[ph_h[31 -: SINE_TABLE_BITS]];
      WK_SAW:    wave_v = 17'($signed(ph_h[31:17]));
      WK_SQUARE: wave_v = ph_h[31] ? -17'sd16384 : 17'sd16384;
      WK_TRI: begin
        if (tri_u < 17'd32768)      wave_v = $signed(tri_u);
        else if (tri_u < 17'd98304) wave_v = 17'($signed(19'd65536) - $signed({2'b0, tri_u}));
        else                        wave_v = 17'($signed({2'b0, tri_u}) - $signed(19'd131072));
      end
      default:   wave_v = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Shared multiplier
  // ---------------------------------------------------------------------
  logic signed [MUL_A_W-1:0] op_a_r;
  logic signed [MUL_B_W-1:0] op_b_r;
  logic signed [MUL_P_W-1:0] prod;

  hves_mul u_mul (
    .clk (clk),
    .a_i (op_a_r),
    .b_i (op_b_r),
    .p_o (prod)
  );

  // ---------------------------------------------------------------------
  // Envelope position, decided at the start of each request
  // ---------------------------------------------------------------------
  logic [17:0]           vr;
  logic [INDEX_BITS-1:0] diff;
  assign vr   = 18'(peak_r) * 18'(vc.rel_div);
  assign diff = idx_w_r - INDEX_BITS'(vc.attack);

  logic        att_r, past_r, hit_r, neg_r;
  logic [17:0] relg_r;
  logic [28:0] g_r;
  logic [5:0]  sh_r;
  logic [29:0] m_r;
  logic signed [MUL_A_W-1:0] acc_r, mix, mag;
  logic [49:0] plo_r;
  logic [62:0] full, full2;
  logic [62:0] xs;
  logic [XCLAMP_W-1:0] xc;
  logic [22:0] q;
  logic [28:0] g_now;
  logic [15:0] res_data;
  logic        res_clip;

  assign mix   = rest_r ? '0 : acc_r;
  assign mag   = mix[MUL_A_W-1] ? -mix : mix;
  assign g_now = att_r ? prod[28:0] : 29'(relg_r);
  assign full  = (63'(prod[46:0]) << 16) + 63'(plo_r);
  assign xs    = full >> sh_r;
  assign xc    = (xs > 63'({XCLAMP_W{1'b1}})) ? {XCLAMP_W{1'b1}} : xs[XCLAMP_W-1:0];
  assign full2 = full;
  assign q     = 23'(full2 >> RECIP_SHIFT);

  // Truncate toward zero on the magnitude, then restore sign and saturate.
  always_comb begin
    res_clip = 1'b0;
    if (past_r) begin
      res_data = '0;
    end else if (!neg_r) begin
      if (q > 23'd32767) begin
        res_data = 16'h7fff;
        res_clip = 1'b1;
      end else begin
        res_data = q[15:0];
      end
    end else begin
      if (q > 23'd32768) begin
        res_data = 16'h8000;
        res_clip = 1'b1;
      end else begin
        res_data = 16'(-q);
      end
    end
  end

  logic [15:0] out_data_r;
  logic        out_clip_r, out_end_r;

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_req) begin
          ph_w_r  <= ph_cur;
          idx_w_r <= idx_cur;
          rest_r  <= (in_tdata == 24'd0);
        end
      end
      ST_W0: begin
        acc_r  <= MUL_A_W'(wave_v) <<< 15;
        att_r  <= idx_w_r <= INDEX_BITS'(vc.attack);
        past_r <= (idx_w_r > INDEX_BITS'(vc.attack)) && (diff > INDEX_BITS'(vr));
        hit_r  <= (idx_w_r > INDEX_BITS'(vc.attack)) && (diff == INDEX_BITS'(vr));
        relg_r <= vr - diff[17:0];
      end
      ST_W1: begin
        op_a_r <= MUL_A_W'(wave_v);
        op_b_r <= $signed({1'b0, vc.w1});
      end
      ST_W2: begin
        op_a_r <= MUL_A_W'(wave_v);
        op_b_r <= $signed({1'b0, vc.w2});
      end
      ST_W3: begin
        acc_r  <= acc_r + MUL_A_W'(prod);
        op_a_r <= $signed(MUL_A_W'(idx_w_r));
        op_b_r <= $signed({2'b0, peak_r});
      end
      ST_W4: acc_r <= acc_r + MUL_A_W'(prod);
      ST_GAIN: begin
        g_r    <= g_now;
        neg_r  <= mix[MUL_A_W-1];
        op_a_r <= mag;
        op_b_r <= $signed({1'b0, g_now[15:0]});
        sh_r   <= 6'd30 + 6'(att_r ? vc.att_k : vc.rel_k);
        m_r    <= att_r ? vc.att_m : vc.rel_m;
      end
      ST_P0: op_b_r <= $signed({4'b0, g_r[28:16]});
      ST_P1: plo_r  <= prod[49:0];
      ST_P2: begin
        op_a_r <= $signed(MUL_A_W'(xc));
        op_b_r <= $signed({1'b0, m_r[15:0]});
      end
      ST_D0: op_b_r <= $signed({3'b0, m_r[29:16]});
      ST_D1: plo_r  <= prod[49:0];
      ST_D2: begin
        if (ctrl.finish) begin
          out_data_r <= res_data;
          out_clip_r <= res_clip;
          out_end_r  <= past_r || hit_r;
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = {out_end_r, out_clip_r};

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  `HVES_ASSERT_NXT(a_busy_after_req, in_tvalid && in_tready, !in_tready, "request taken while busy")
  `HVES_ASSERT_IMP(a_end_silent, out_tvalid && out_tuser[1], out_tdata == 16'h0000 && !out_tuser[0], "ended envelope not silent")
  `HVES_ASSERT_IMP(a_clip_full_scale, out_tvalid && out_tuser[0], out_tdata == 16'h7fff || out_tdata == 16'h8000, "clip flag without full scale")

endmodule

/* hdl/hves_mul.sv */
`timescale 1ns / 1ps
module hves_mul import hves_pkg::*; (
  input  logic                       clk,
  input  logic signed [MUL_A_W-1:0]  a_i,
  input  logic signed [MUL_B_W-1:0]  b_i,
  output logic signed [MUL_P_W-1:0]  p_o
);

  logic signed [MUL_P_W-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= MUL_P_W'(a_i) * MUL_P_W'(b_i);
  end

  assign p_o = p_r;

endmodule
